>>> rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the summed-area table query unit.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int CFG_W   = 9;   // size register width
  localparam int COORD_W = 8;   // query coordinate width
  localparam int SUM_W   = 34;  // region sum width
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // table reads of one query, in issue order
  localparam logic [1:0] TERM_BR = 2'd0;  // bottom-right, added
  localparam logic [1:0] TERM_BL = 2'd1;  // bottom, left of region, subtracted
  localparam logic [1:0] TERM_TR = 2'd2;  // above region, right, subtracted
  localparam logic [1:0] TERM_TL = 2'd3;  // above and left, added

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_PREP,
    ST_LD_WRITE,
    ST_Q_CHECK,
    ST_Q_READ,
    ST_Q_LAST,
    ST_Q_DONE
  } sat_state_t;

  typedef struct packed {
    logic       cap;        // latch the input transaction
    logic       ld_prep;    // apply restart, add value, read entry above
    logic       ld_commit;  // write table entry, advance raster position
    logic       q_rd;       // issue one query table read
    logic [1:0] rd_idx;     // which corner is read
    logic       q_fail;     // query rejected, result is an error
    logic       out_load;   // move result into output register
  } sat_cmd_t;

  typedef struct packed {
    logic is_query;
    logic load_full;
    logic q_bad;
    logic out_free;
  } sat_sts_t;

endpackage

>>> rtl/sat_regs.sv
// ----------------------------------------------------------------------------
// sat_regs
// Size registers on the APB port, with clamping to the table dimensions.
// ----------------------------------------------------------------------------
module sat_regs
  import sat_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready,
  output logic [$clog2(MAX_COLS+1)-1:0] cols,
  output logic [$clog2(MAX_ROWS+1)-1:0] rows,
  output logic                          cfg_clear
);

  localparam int CR_W = $clog2(MAX_ROWS + 1);
  localparam int CC_W = $clog2(MAX_COLS + 1);

  logic [CFG_W-1:0] cols_reg_r;
  logic [CFG_W-1:0] rows_reg_r;
  logic             wr_en;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite;
  // any write drops the loaded matrix
  assign cfg_clear = wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_reg_r <= CFG_W'(256);
      rows_reg_r <= CFG_W'(256);
    end else if (wr_en) begin
      unique case (paddr[PADDR_W-1])
        REG_COLS: cols_reg_r <= pwdata[CFG_W-1:0];
        REG_ROWS: rows_reg_r <= pwdata[CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[PADDR_W-1])
      REG_COLS: prdata = PDATA_W'(cols_reg_r);
      REG_ROWS: prdata = PDATA_W'(rows_reg_r);
      default:  prdata = '0;
    endcase
  end

  // zero acts as one, oversize acts as the table dimension
  always_comb begin
    if (cols_reg_r == '0) begin
      cols = CC_W'(1);
    end else if (32'(cols_reg_r) > MAX_COLS) begin
      cols = CC_W'(MAX_COLS);
    end else begin
      cols = CC_W'(cols_reg_r);
    end
    if (rows_reg_r == '0) begin
      rows = CR_W'(1);
    end else if (32'(rows_reg_r) > MAX_ROWS) begin
      rows = CR_W'(MAX_ROWS);
    end else begin
      rows = CR_W'(rows_reg_r);
    end
  end

endmodule

>>> rtl/sat_ctrl.sv
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer for loads and queries; drives datapath commands.
// ----------------------------------------------------------------------------
module sat_ctrl
  import sat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sat_sts_t sts,
  output sat_cmd_t cmd
);

  sat_state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= TERM_BR;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = sts.is_query ? ST_Q_CHECK : ST_LD_PREP;
        end
      end
      ST_LD_PREP: begin
        cmd.ld_prep = 1'b1;
        state_nxt   = sts.load_full ? ST_IDLE : ST_LD_WRITE;
      end
      ST_LD_WRITE: begin
        cmd.ld_commit = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_Q_CHECK: begin
        if (sts.q_bad) begin
          cmd.q_fail = 1'b1;
          state_nxt  = ST_Q_DONE;
        end else begin
          cmd.q_rd   = 1'b1;
          cmd.rd_idx = TERM_BR;
          cnt_nxt    = TERM_BL;
          state_nxt  = ST_Q_READ;
        end
      end
      ST_Q_READ: begin
        cmd.q_rd   = 1'b1;
        cmd.rd_idx = cnt_r;
        cnt_nxt    = 2'(cnt_r + 2'd1);
        if (cnt_r == TERM_TL) begin
          state_nxt = ST_Q_LAST;
        end
      end
      ST_Q_LAST: begin
        // last read data folds into the accumulator this cycle
        state_nxt = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register is occupied");

  a_write_after_prep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LD_WRITE |-> $past(state_r) == ST_LD_PREP)
    else $error("table write without a preceding load preparation");
`endif

endmodule

>>> rtl/sat_dpath.sv
// ----------------------------------------------------------------------------
// sat_dpath
// Table memory, raster load position, corner accumulator, output register.
// ----------------------------------------------------------------------------
module sat_dpath
  import sat_pkg::*;
#(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int VALUE_BITS = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_op,
  input  logic                          in_restart,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  input  logic [COORD_W-1:0]            in_row_top,
  input  logic [COORD_W-1:0]            in_col_left,
  input  logic [COORD_W-1:0]            in_row_bottom,
  input  logic [COORD_W-1:0]            in_col_right,
  input  logic [$clog2(MAX_COLS+1)-1:0] cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  logic                          cfg_clear,
  input  sat_cmd_t                      cmd,
  output sat_sts_t                      sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SUM_W-1:0]       out_region_sum,
  output logic                          out_query_status
);

  localparam int CR_W    = $clog2(MAX_ROWS + 1);
  localparam int CC_W    = $clog2(MAX_COLS + 1);
  localparam int RS_W    = VALUE_BITS + $clog2(MAX_COLS);
  localparam int TABLE_W = RS_W + $clog2(MAX_ROWS);
  localparam int ACC_W   = (TABLE_W > SUM_W) ? TABLE_W : SUM_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [ADDR_W-1:0] addr_of(input int r, input int c);
    return ADDR_W'(r * MAX_COLS + c);
  endfunction

  // latched transaction
  logic                         restart_r;
  logic signed [VALUE_BITS-1:0] value_r;
  logic [COORD_W-1:0]           top_r, left_r, bot_r, right_r;

  // raster load position
  logic [CR_W-1:0]        load_row_r, eff_row;
  logic [CC_W-1:0]        load_col_r, eff_col;
  logic signed [RS_W-1:0] rsum_r, eff_rsum;

  // table memory
  logic [TABLE_W-1:0]        mem [DEPTH];
  logic                      mem_re, mem_we;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic signed [TABLE_W-1:0] wr_data, above;
  logic signed [TABLE_W-1:0] rd_data_r;
  logic                      rd_zero;
  logic                      rd_zero_r;
  logic [1:0]                rd_tag_r;
  logic                      rd_pend_r;

  logic signed [ACC_W-1:0] acc_r, term;
  logic                    fail_r;
  logic                    loaded;

  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_status_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      restart_r <= in_restart;
      value_r   <= in_value;
      top_r     <= in_row_top;
      left_r    <= in_col_left;
      bot_r     <= in_row_bottom;
      right_r   <= in_col_right;
    end
  end

  assign eff_row  = restart_r ? '0 : load_row_r;
  assign eff_col  = restart_r ? '0 : load_col_r;
  assign eff_rsum = restart_r ? '0 : rsum_r;

  assign loaded = (32'(bot_r) < 32'(load_row_r)) ||
                  ((32'(bot_r) == 32'(load_row_r)) && (32'(right_r) < 32'(load_col_r)));

  always_comb begin
    sts           = '0;
    sts.is_query  = in_op;
    sts.load_full = 32'(eff_row) >= 32'(rows);
    sts.q_bad     = (top_r > bot_r) || (left_r > right_r) ||
                    (32'(bot_r) >= 32'(rows)) || (32'(right_r) >= 32'(cols)) || !loaded;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      rsum_r     <= '0;
    end else if (cfg_clear) begin
      load_row_r <= '0;
      load_col_r <= '0;
      rsum_r     <= '0;
    end else if (cmd.ld_prep) begin
      load_row_r <= eff_row;
      load_col_r <= eff_col;
      if (sts.load_full) begin
        rsum_r <= eff_rsum;
      end else begin
        rsum_r <= eff_rsum + RS_W'(value_r);
      end
    end else if (cmd.ld_commit) begin
      if (32'(load_col_r) + 1 >= 32'(cols)) begin
        load_col_r <= '0;
        load_row_r <= CR_W'(load_row_r + 1'b1);
        rsum_r     <= '0;
      end else begin
        load_col_r <= CC_W'(load_col_r + 1'b1);
      end
    end
  end

  // read address: entry above on a load, one corner per cycle on a query;
  // corners in the virtual row or column before the table read as zero
  always_comb begin
    mem_re  = 1'b0;
    rd_addr = '0;
    rd_zero = 1'b0;
    if (cmd.ld_prep) begin
      mem_re = (eff_row != '0);
      if (eff_row != '0) begin
        rd_addr = addr_of(int'(eff_row) - 1, int'(eff_col));
      end
    end else if (cmd.q_rd) begin
      mem_re = 1'b1;
      case (cmd.rd_idx)
        TERM_BR: rd_addr = addr_of(int'(bot_r), int'(right_r));
        TERM_BL: begin
          rd_zero = (left_r == '0);
          if (left_r != '0) begin
            rd_addr = addr_of(int'(bot_r), int'(left_r) - 1);
          end
        end
        TERM_TR: begin
          rd_zero = (top_r == '0);
          if (top_r != '0) begin
            rd_addr = addr_of(int'(top_r) - 1, int'(right_r));
          end
        end
        TERM_TL: begin
          rd_zero = (top_r == '0) || (left_r == '0);
          if ((top_r != '0) && (left_r != '0)) begin
            rd_addr = addr_of(int'(top_r) - 1, int'(left_r) - 1);
          end
        end
        default: rd_zero = 1'b1;
      endcase
    end
  end

  assign mem_we  = cmd.ld_commit;
  assign wr_addr = addr_of(int'(load_row_r), int'(load_col_r));
  assign above   = (load_row_r != '0) ? rd_data_r : '0;
  assign wr_data = TABLE_W'(rsum_r) + above;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    rd_zero_r <= rd_zero;
    rd_tag_r  <= cmd.rd_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.q_rd;
    end
  end

  assign term = rd_zero_r ? '0 : ACC_W'(rd_data_r);

  always_ff @(posedge clk) begin
    if (cmd.q_rd && (cmd.rd_idx == TERM_BR)) begin
      acc_r <= '0;
    end else if (rd_pend_r) begin
      if ((rd_tag_r == TERM_BL) || (rd_tag_r == TERM_TR)) begin
        acc_r <= acc_r - term;
      end else begin
        acc_r <= acc_r + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_fail) begin
      fail_r <= 1'b1;
    end else if (cmd.q_rd && (cmd.rd_idx == TERM_BR)) begin
      fail_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sum_r    <= fail_r ? '0 : acc_r[SUM_W-1:0];
      out_status_r <= fail_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_region_sum   = out_sum_r;
  assign out_query_status = out_status_r;

`ifndef NO_ASSERTIONS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(load_col_r) < 32'(cols))
    else $error("load column past configured width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(load_row_r) <= 32'(rows))
    else $error("load row past configured height");
`endif

endmodule

>>> rtl/summed_area_table_query_unit.sv
// ----------------------------------------------------------------------------
// summed_area_table_query_unit
// Integral-image engine: raster loads build the prefix table, queries return
// inclusive rectangle sums from four table corners.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   op, restart, value, 4 coordinates
//  out      source     out_valid / out_stall region_sum, query_status
//  cfg      APB slave  psel/penable/pready   cols_in_use @0x0, rows_in_use @0x4
//
//  A load runs accept, read entry above, write entry, and ends after the read
//  step when the matrix is full and the load is dropped; a query runs accept,
//  check with the first corner read, three more reads, final add, result load,
//  and goes from check to result load if rejected. One table access per cycle.
//  One transaction is in flight at a time; the output register lets the next
//  transaction be accepted while a result waits, a query result then waits
//  in its last cycle while out_stall holds the previous one.
//  Reset is synchronous; the table is not cleared, the load
//  position tracks which entries hold valid data.
// ----------------------------------------------------------------------------
module summed_area_table_query_unit
  import sat_pkg::*;
#(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int VALUE_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic                         in_restart,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic [COORD_W-1:0]           in_row_top,
  input  logic [COORD_W-1:0]           in_col_left,
  input  logic [COORD_W-1:0]           in_row_bottom,
  input  logic [COORD_W-1:0]           in_col_right,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SUM_W-1:0]      out_region_sum,
  output logic                         out_query_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [PDATA_W-1:0]           pwdata,
  output logic [PDATA_W-1:0]           prdata,
  output logic                         pready
);

  localparam int CR_W = $clog2(MAX_ROWS + 1);
  localparam int CC_W = $clog2(MAX_COLS + 1);

  logic [CC_W-1:0] cols;
  logic [CR_W-1:0] rows;
  logic            cfg_clear;
  sat_cmd_t        cmd;
  sat_sts_t        sts;

  sat_regs #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cols      (cols),
    .rows      (rows),
    .cfg_clear (cfg_clear)
  );

  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sat_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_restart       (in_restart),
    .in_value         (in_value),
    .in_row_top       (in_row_top),
    .in_col_left      (in_col_left),
    .in_row_bottom    (in_row_bottom),
    .in_col_right     (in_col_right),
    .cols             (cols),
    .rows             (rows),
    .cfg_clear        (cfg_clear),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_region_sum   (out_region_sum),
    .out_query_status (out_query_status)
  );

endmodule

>>> sim/summed_area_table_query_unit_tb.sv
// ----------------------------------------------------------------------------
// summed_area_table_query_unit_tb
// Self-checking bench for the integral-image query unit. It loads matrices
// in raster order and queries rectangles. A scoreboard keeps its own prefix
// table and load position, and it predicts each query result. Results are
// checked in order. The size registers are written over the APB port while
// the unit is idle, and each write is read back.
// ----------------------------------------------------------------------------
module summed_area_table_query_unit_tb;
  import sat_pkg::*;

  localparam int VAL_W         = 18;
  localparam int MAX_DIM       = 256;
  localparam int ITEMS_TOTAL   = 1100;
  localparam int SETTLE_CYCLES = 12;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_QUERY   = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic signed [VAL_W-1:0] VALUE_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VALUE_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic                    op;
    logic                    restart;
    logic signed [VAL_W-1:0] value;
    logic [COORD_W-1:0]      row_top;
    logic [COORD_W-1:0]      col_left;
    logic [COORD_W-1:0]      row_bottom;
    logic [COORD_W-1:0]      col_right;
  } sat_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] region_sum;
    logic                    query_status;
  } sat_result_t;

  // --------------------------------------------------------------------------
  // prefix-sum predictor and in-order result checker
  // --------------------------------------------------------------------------
  class sat_scoreboard;
    longint      prefix_tbl[MAX_DIM*MAX_DIM];
    longint      row_acc;
    int unsigned load_row;
    int unsigned load_col;
    int unsigned cols_reg;
    int unsigned rows_reg;
    sat_result_t expected_q[$];
    int          errors;

    function new();
      cols_reg = MAX_DIM;
      rows_reg = MAX_DIM;
      errors   = 0;
      clear_load();
    endfunction

    function void clear_load();
      row_acc  = 0;
      load_row = 0;
      load_col = 0;
    endfunction

    function int unsigned eff_cols();
      if (cols_reg == 0) return 1;
      return (cols_reg > MAX_DIM) ? MAX_DIM : cols_reg;
    endfunction

    function int unsigned eff_rows();
      if (rows_reg == 0) return 1;
      return (rows_reg > MAX_DIM) ? MAX_DIM : rows_reg;
    endfunction

    function int unsigned loaded_count();
      return load_row * eff_cols() + load_col;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // any register write throws away the loaded matrix
    function void write_size(bit is_rows, int unsigned val);
      if (is_rows) rows_reg = val;
      else cols_reg = val;
      clear_load();
    endfunction

    // border row / column -1 reads as zero
    function longint entry(int r, int c);
      if (r < 0 || c < 0) return 0;
      return prefix_tbl[r*MAX_DIM + c];
    endfunction

    // returns 0 for a load that the unit drops
    function bit note_input(sat_item_t it);
      int unsigned cols, rows;
      int          r1, c1, r2, c2;
      bit          bad, loaded;
      longint      s;
      sat_result_t res;
      cols = eff_cols();
      rows = eff_rows();
      if (it.op == OP_LOAD) begin
        if (it.restart) clear_load();
        if (load_row >= rows) return 0;
        row_acc += longint'($signed(it.value));
        prefix_tbl[load_row*MAX_DIM + load_col] = row_acc + entry(int'(load_row) - 1,
                                                                   int'(load_col));
        load_col++;
        if (load_col >= cols) begin
          load_col = 0;
          load_row++;
          row_acc  = 0;
        end
        return 1;
      end
      r1 = int'(it.row_top);
      c1 = int'(it.col_left);
      r2 = int'(it.row_bottom);
      c2 = int'(it.col_right);
      bad    = (r1 > r2) || (c1 > c2) || (r2 >= rows) || (c2 >= cols);
      loaded = (r2 < load_row) || (r2 == load_row && c2 < load_col);
      if (bad || !loaded) begin
        res.region_sum   = '0;
        res.query_status = STATUS_ERR;
      end else begin
        s = entry(r2, c2) - entry(r2, c1 - 1) - entry(r1 - 1, c2) + entry(r1 - 1, c1 - 1);
        res.region_sum   = s[SUM_W-1:0];
        res.query_status = STATUS_OK;
      end
      expected_q = {expected_q, res};
      return 1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(sat_result_t got);
      sat_result_t exp_res;
      if (expected_q.size() == 0) begin
        report("result transaction with no query outstanding");
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.query_status !== exp_res.query_status)
        report($sformatf("query_status got %b expected %b",
                         got.query_status, exp_res.query_status));
      if (got.region_sum !== exp_res.region_sum)
        report($sformatf("region_sum got %0d expected %0d",
                         got.region_sum, exp_res.region_sum));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and unit
  // --------------------------------------------------------------------------
  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_op;
  logic                    in_restart;
  logic signed [VAL_W-1:0] in_value;
  logic [COORD_W-1:0]      in_row_top;
  logic [COORD_W-1:0]      in_col_left;
  logic [COORD_W-1:0]      in_row_bottom;
  logic [COORD_W-1:0]      in_col_right;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SUM_W-1:0] out_region_sum;
  logic                    out_query_status;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  sat_scoreboard sb;
  int            items_done;
  int            send_idle_pct;
  int            recv_stall_pct;

  summed_area_table_query_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_restart       (in_restart),
    .in_value         (in_value),
    .in_row_top       (in_row_top),
    .in_col_left      (in_col_left),
    .in_row_bottom    (in_row_bottom),
    .in_col_right     (in_col_right),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_region_sum   (out_region_sum),
    .out_query_status (out_query_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[summed_area_table_query_unit] ERROR");
    $finish;
  end

  // result side: random stall, check every accepted result
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
        sb.check_result('{region_sum: out_region_sum, query_status: out_query_status});
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_item(input sat_item_t it);
    bit counted;
    if (items_done < 370) begin
      send_idle_pct  = 19;
      recv_stall_pct = 73;
    end else if (items_done < 740) begin
      send_idle_pct  = 73;
      recv_stall_pct = 19;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= it.op;
    in_restart    <= it.restart;
    in_value      <= it.value;
    in_row_top    <= it.row_top;
    in_col_left   <= it.col_left;
    in_row_bottom <= it.row_bottom;
    in_col_right  <= it.col_right;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    counted = sb.note_input(it);
    if (counted) items_done++;
  endtask

  // one write then a read back of the same register
  task automatic cfg_write(input logic reg_idx, input int unsigned val);
    logic [PDATA_W-1:0] data;
    data              = $urandom;
    data[CFG_W-1:0]   = val[CFG_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_size(reg_idx == REG_ROWS, val & 32'h1FF);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CFG_W-1:0] !== data[CFG_W-1:0])
      sb.report($sformatf("register %0d read %0h expected %0h",
                          reg_idx, prdata[CFG_W-1:0], data[CFG_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // loads make no result, so wait past the last one before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input int unsigned cols_val, input int unsigned rows_val);
    settle();
    cfg_write(REG_COLS, cols_val);
    cfg_write(REG_ROWS, rows_val);
  endtask

  function automatic sat_item_t rand_item();
    sat_item_t it;
    it.op         = 1'($urandom_range(1));
    it.restart    = 1'($urandom_range(1));
    it.value      = VAL_W'($urandom);
    it.row_top    = COORD_W'($urandom);
    it.col_left   = COORD_W'($urandom);
    it.row_bottom = COORD_W'($urandom);
    it.col_right  = COORD_W'($urandom);
    return it;
  endfunction

  function automatic sat_item_t mk_load(input logic restart, input int value);
    sat_item_t it;
    it         = rand_item();
    it.op      = OP_LOAD;
    it.restart = restart;
    it.value   = VAL_W'(value);
    return it;
  endfunction

  function automatic sat_item_t mk_query(input int rt, input int cl, input int rb,
                                         input int cr);
    sat_item_t it;
    it            = rand_item();
    it.op         = OP_QUERY;
    it.row_top    = COORD_W'(rt);
    it.col_left   = COORD_W'(cl);
    it.row_bottom = COORD_W'(rb);
    it.col_right  = COORD_W'(cr);
    return it;
  endfunction

  // mostly raster loads and queries inside the loaded area, some broken ones
  task automatic run_phase(input int n_items, input int load_pct);
    sat_item_t   it;
    int          start;
    int unsigned cols, rows, n, idx, pick;
    start = items_done;
    while (items_done - start < n_items) begin
      it   = rand_item();
      cols = sb.eff_cols();
      rows = sb.eff_rows();
      n    = sb.loaded_count();
      pick = $urandom_range(99);
      if (pick < load_pct) begin
        it.op      = OP_LOAD;
        it.restart = (n == cols * rows) ? 1'($urandom_range(1))
                                        : ($urandom_range(49) == 0);
        case ($urandom_range(9))
          0: it.value = VALUE_MAX;
          1: it.value = VALUE_MIN;
          default: ;
        endcase
      end else if (pick < 95 && n != 0) begin
        it.op         = OP_QUERY;
        idx           = $urandom_range(n - 1);
        it.row_bottom = COORD_W'(idx / cols);
        it.col_right  = COORD_W'(idx % cols);
        it.row_top    = COORD_W'($urandom_range(it.row_bottom));
        it.col_left   = COORD_W'($urandom_range(it.col_right));
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(2))
            0: if (n < cols * rows) begin
              it.row_bottom = COORD_W'(n / cols);
              it.col_right  = COORD_W'(n % cols);
            end
            1: it.row_top   = COORD_W'(it.row_bottom + 1);
            default: it.col_right = COORD_W'(cols);
          endcase
        end
      end else begin
        it.op = OP_QUERY;
      end
      send_item(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned size_cols [10] = '{4, 0, 1, 256, 511, 1, 2, 3, 7, 16};
    int unsigned size_rows [10] = '{3, 0, 1, 1, 2, 256, 511, 5, 2, 16};
    int unsigned c, r;
    sb             = new();
    items_done     = 0;
    send_idle_pct  = 19;
    recv_stall_pct = 73;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_LOAD;
    in_restart    <= 1'b0;
    in_value      <= '0;
    in_row_top    <= '0;
    in_col_left   <= '0;
    in_row_bottom <= '0;
    in_col_right  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset sizes (256 x 256)
    send_item(mk_query(0, 0, 0, 0));          // nothing loaded yet
    send_item(mk_load(1'b1, VALUE_MAX));
    send_item(mk_load(1'b0, VALUE_MIN));
    send_item(mk_load(1'b0, 0));
    send_item(mk_query(0, 0, 0, 0));
    send_item(mk_query(0, 0, 0, 1));
    send_item(mk_query(0, 1, 0, 2));
    send_item(mk_query(1, 0, 0, 2));          // rows inverted
    send_item(mk_query(0, 2, 0, 1));          // columns inverted
    send_item(mk_query(0, 0, 0, 3));          // just past the loaded area
    send_item(mk_query(0, 0, 255, 255));
    send_item(mk_query(255, 255, 255, 255));
    begin
      sat_item_t it;
      it         = mk_query(0, 0, 0, 2);
      it.restart = 1'b1;                      // ignored on a query
      send_item(it);
    end
    send_item(mk_load(1'b1, 5));              // restart mid-matrix
    send_item(mk_query(0, 0, 0, 0));
    send_item(mk_query(0, 0, 0, 1));
    send_item(mk_load(1'b0, -3));
    send_item(mk_query(0, 0, 0, 1));

    for (int i = 0; i < 10; i++) begin
      set_size(size_cols[i], size_rows[i]);
      if (sb.eff_cols() * sb.eff_rows() > 64) run_phase(150, 75);
      else run_phase($urandom_range(40, 90), 60);
    end
    while (items_done < ITEMS_TOTAL) begin
      c = $urandom_range(1, 12);
      r = $urandom_range(1, 12);
      set_size(c, r);
      run_phase($urandom_range(40, 90), 60);
    end

    settle();
    if (sb.errors == 0) begin
      $display("[summed_area_table_query_unit] OK");
    end else begin
      $display("[summed_area_table_query_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sat_pkg.sv
rtl/sat_regs.sv
rtl/sat_ctrl.sv
rtl/sat_dpath.sv
rtl/summed_area_table_query_unit.sv
sim/summed_area_table_query_unit_tb.sv
